### rtl/multi_needle_caseless_byte_matcher_top_assert.svh
// Assertion macros used by the checker module of the matcher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MULTI_NEEDLE_CASELESS_BYTE_MATCHER_TOP_ASSERT_SVH
`define MULTI_NEEDLE_CASELESS_BYTE_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication.
`define MNM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MNM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mnm_pkg.sv
`default_nettype none

package mnm_pkg;

    // Default sizing of the matcher.
    localparam int NEEDLES_DEF   = 4;
    localparam int MAX_LEN_DEF   = 8;

    // Fixed register layout.
    localparam int NEEDLE_REGS   = 4;
    localparam int NEEDLE_W      = 64;
    localparam int LENGTHS_W     = 16;
    localparam int LEN_W         = 4;
    localparam int COUNT_W       = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int HIT_IDX_W     = 2;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTHS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT    = 3'd5;

    // ASCII case bounds.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic                 hit;
        logic [HIT_IDX_W-1:0] hit_needle;
        logic                 found;
    } out_word_t;

    // Control of the window stage.
    typedef struct packed {
        logic valid;
        logic first;
    } stage_ctl_t;

    // Result of the needle compare.
    typedef struct packed {
        logic                 hit;
        logic [HIT_IDX_W-1:0] which;
    } match_t;

    // Fold ASCII upper case letters to lower case.
    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/mnm_window.sv
`default_nettype none

module mnm_window #(
    parameter int MAX_LEN = mnm_pkg::MAX_LEN_DEF,
    parameter int SEEN_W  = $clog2(MAX_LEN + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    take,
    input  wire logic                    adv,
    input  wire mnm_pkg::in_word_t       in_word,
    output logic [MAX_LEN-1:0][7:0]      window,
    output logic [SEEN_W-1:0]            seen,
    output mnm_pkg::stage_ctl_t          ctl
);
    import mnm_pkg::*;

    logic [MAX_LEN-1:0][7:0] window_reg;
    logic [MAX_LEN-1:0][7:0] window_next;
    logic [SEEN_W-1:0]       seen_reg;
    logic [SEEN_W-1:0]       seen_next;
    logic                    valid_reg;
    logic                    first_reg;

    // Shift the folded byte in, after clearing on the first byte of a file.
    always_comb
    begin
        for (int j = MAX_LEN - 1; j > 0; j--)
        begin
            window_next[j] = in_word.first_byte ? 8'h00 : window_reg[j-1];
        end
        window_next[0] = fold(in_word.data_byte);
        if (in_word.first_byte)
        begin
            seen_next = SEEN_W'(1);
        end
        else if (seen_reg < SEEN_W'(MAX_LEN))
        begin
            seen_next = seen_reg + SEEN_W'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    // The window and fill count move only when a word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                window_reg <= window_next;
                seen_reg   <= seen_next;
                valid_reg  <= 1'b1;
            end
            else if (adv)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // First-of-file mark travels with the word.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            first_reg <= in_word.first_byte;
        end
    end

    assign window    = window_reg;
    assign seen      = seen_reg;
    assign ctl.valid = valid_reg;
    assign ctl.first = first_reg;

endmodule

`default_nettype wire

### rtl/mnm_compare.sv
`default_nettype none

module mnm_compare #(
    parameter int SLOTS   = mnm_pkg::NEEDLE_REGS,
    parameter int MAX_LEN = mnm_pkg::MAX_LEN_DEF,
    parameter int SEEN_W  = $clog2(MAX_LEN + 1)
) (
    input  wire logic [MAX_LEN-1:0][7:0]                window,
    input  wire logic [SEEN_W-1:0]                      seen,
    input  wire logic [SLOTS-1:0][mnm_pkg::NEEDLE_W-1:0] needles,
    input  wire logic [mnm_pkg::LENGTHS_W-1:0]          lengths,
    input  wire logic [mnm_pkg::COUNT_W-1:0]            count,
    output mnm_pkg::match_t                             match
);
    import mnm_pkg::*;

    logic [SLOTS-1:0] ends_here;

    // Every needle is checked against the window in parallel.
    always_comb
    begin
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] pos;
        logic             ok;
        for (int k = 0; k < SLOTS; k++)
        begin
            len = lengths[LEN_W*k +: LEN_W];
            ok  = (len != '0) && (len <= LEN_W'(MAX_LEN))
                  && (LEN_W'(seen) >= len) && (COUNT_W'(k) < count);
            for (int j = 0; j < MAX_LEN; j++)
            begin
                // Window entry j holds needle byte len-1-j.
                pos = len - LEN_W'(j) - LEN_W'(1);
                if (LEN_W'(j) < len)
                begin
                    if (window[j] != fold(needles[k][8*pos[2:0] +: 8]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
            ends_here[k] = ok;
        end
    end

    // Lowest-numbered needle wins.
    always_comb
    begin
        match.hit   = 1'b0;
        match.which = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (ends_here[k])
            begin
                match.hit   = 1'b1;
                match.which = HIT_IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/multi_needle_caseless_byte_matcher_top.sv
`default_nettype none

// Caseless multi-needle byte matcher. Each accepted word carries one file byte and a
// first-of-file mark; each produces one result word telling whether an active needle
// ends at that byte, the lowest such needle, and a flag that stays set once any needle
// has matched in the current file. A new word is taken every cycle while in_stall is
// low; a taken byte is held in the window shift register while the parallel needle
// compare feeds the output register, which loads when it is empty or not stalled.
// Needles must be written through the configuration port while the stream is idle;
// the block itself does not enforce this.
module multi_needle_caseless_byte_matcher_top #(
    parameter int NEEDLES = mnm_pkg::NEEDLES_DEF,
    parameter int MAX_NEEDLE_LEN = mnm_pkg::MAX_LEN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire mnm_pkg::in_word_t                 in_word,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output mnm_pkg::out_word_t                     out_word,
    input  wire logic                              cfg_we,
    input  wire logic [mnm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mnm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mnm_pkg::*;

    localparam int SLOTS  = (NEEDLES < NEEDLE_REGS) ? NEEDLES : NEEDLE_REGS;
    localparam int SEEN_W = $clog2(MAX_NEEDLE_LEN + 1);

    logic [SLOTS-1:0][NEEDLE_W-1:0] needle_reg;
    logic [LENGTHS_W-1:0]           lengths_reg;
    logic [COUNT_W-1:0]             count_reg;

    logic [MAX_NEEDLE_LEN-1:0][7:0] window;
    logic [SEEN_W-1:0]              seen;
    stage_ctl_t                     ctl;
    match_t                         match;

    logic      take;
    logic      adv;
    logic      found_reg;
    logic      found_next;
    logic      out_valid_reg;
    out_word_t out_word_reg;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg  <= '0;
            lengths_reg <= '0;
            count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (cfg_index == CFG_NEEDLE_A + CFG_INDEX_W'(k))
                begin
                    needle_reg[k] <= cfg_data;
                end
            end
            if (cfg_index == CFG_LENGTHS)
            begin
                lengths_reg <= cfg_data[LENGTHS_W-1:0];
            end
            if (cfg_index == CFG_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    // Handshake: the window stage empties whenever the output register can load.
    assign adv      = !out_valid_reg || !out_stall;
    assign take     = in_valid && !in_stall;
    assign in_stall = ctl.valid && !adv;

    mnm_window #(
        .MAX_LEN (MAX_NEEDLE_LEN),
        .SEEN_W  (SEEN_W)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .adv     (adv),
        .in_word (in_word),
        .window  (window),
        .seen    (seen),
        .ctl     (ctl)
    );

    mnm_compare #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_NEEDLE_LEN),
        .SEEN_W  (SEEN_W)
    ) u_compare (
        .window  (window),
        .seen    (seen),
        .needles (needle_reg),
        .lengths (lengths_reg),
        .count   (count_reg),
        .match   (match)
    );

    // Sticky flag restarts with each file and includes the current byte.
    assign found_next = (ctl.first ? 1'b0 : found_reg) | match.hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl.valid;
            if (ctl.valid)
            begin
                found_reg <= found_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (adv && ctl.valid)
        begin
            out_word_reg.hit        <= match.hit;
            out_word_reg.hit_needle <= match.which;
            out_word_reg.found      <= found_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

### rtl/mnm_checker.sv
`default_nettype none

`include "multi_needle_caseless_byte_matcher_top_assert.svh"

module mnm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire mnm_pkg::out_word_t                out_word
);
    import mnm_pkg::*;

    // A miss reports needle zero.
    `MNM_ASSERT_NOW(a_miss_idx, out_valid && !out_word.hit, ~|out_word.hit_needle, "index on miss")

    // A hit always sets the sticky flag in the same word.
    `MNM_ASSERT_NOW(a_hit_found, out_valid && out_word.hit, out_word.found, "hit without found")

    // A stalled result holds.
    `MNM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "hold")

    // A taken word yields a result once it has passed the window and output registers.
    `MNM_ASSERT_NOW(a_latency, in_valid && !in_stall, ##2 out_valid, "result missing")

endmodule

bind multi_needle_caseless_byte_matcher_top mnm_checker u_mnm_checker (.*);

`default_nettype wire
